### design/paxos_acceptor_log_table_macros.svh
// ----------------------------------------------------------------------------
// paxos acceptor log table - assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAXOS_ACCEPTOR_LOG_TABLE_MACROS_SVH
`define PAXOS_ACCEPTOR_LOG_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PALT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("palt: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PALT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("palt: next-cycle check failed");

`endif

### design/palt_pkg.sv
// ----------------------------------------------------------------------------
// palt_pkg
// Types, widths and codes shared by the paxos acceptor log table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package palt_pkg;

    // field widths
    localparam int GROUP_W    = 32;
    localparam int IDX_W      = 10;
    localparam int NUM_W      = 63;
    localparam int CODE_W     = 2;
    // wide enough to hold any slot count up to 65536 for range checks
    localparam int WIDE_IDX_W = 17;

    // default table depth
    localparam int LOG_SLOTS_DEF = 1024;

    typedef enum logic {
        OP_PREPARE = 1'b0,
        OP_ACCEPT  = 1'b1
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        CODE_OK     = 2'd0,
        CODE_LOW    = 2'd1,
        CODE_CHOSEN = 2'd2,
        CODE_GROUP  = 2'd3
    } t_code;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    // one slot of the log table
    typedef struct packed {
        logic             used;
        logic [NUM_W-1:0] promised;
        logic [NUM_W-1:0] accepted;
        logic             held;
        logic [NUM_W-1:0] value;
    } t_slot;

    // request as held during the slot lookup
    typedef struct packed {
        t_op                op;
        logic [GROUP_W-1:0] group;
        logic               in_range;
        logic [NUM_W-1:0]   prop;
        logic [NUM_W-1:0]   value;
    } t_req;

    // result transaction
    typedef struct packed {
        t_code            code;
        logic [NUM_W-1:0] prop;
        logic             present;
        logic [NUM_W-1:0] value;
    } t_resp;

endpackage

`default_nettype wire

### design/paxos_acceptor_log_table.sv
// ----------------------------------------------------------------------------
// paxos_acceptor_log_table
// Paxos acceptor over a table of log slots held in one synchronous memory.
// ----------------------------------------------------------------------------
// After reset a clearing pass over all slot addresses marks every slot
// unused; no request is taken during it (own group writes are). It then
// takes one request per cycle while the output is not stalled: the slot is
// read at the accepting edge, decision and write-back happen in lookup once
// the output register is free, and the result is registered there. The order
// is set by the read-modify-write of the slot memory; a request to the slot
// written in the same cycle takes its data from a forwarding register. A
// stalled output holds one result and one request in lookup before input
// stalls. Own-group indexes at or above LOG_SLOTS answer code 1, zero fields.
`default_nettype none

`include "paxos_acceptor_log_table_macros.svh"

module paxos_acceptor_log_table #(
    parameter int LOG_SLOTS = palt_pkg::LOG_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [palt_pkg::GROUP_W-1:0]  i_cfg_wr_data,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_operation,
    input  wire logic [palt_pkg::GROUP_W-1:0]  i_request_group,
    input  wire logic [palt_pkg::IDX_W-1:0]    i_log_index,
    input  wire logic [palt_pkg::NUM_W-1:0]    i_proposal_number,
    input  wire logic [palt_pkg::NUM_W-1:0]    i_value_id,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [palt_pkg::CODE_W-1:0]        o_result_code,
    output logic [palt_pkg::NUM_W-1:0]         o_returned_proposal,
    output logic                               o_value_present,
    output logic [palt_pkg::NUM_W-1:0]         o_returned_value
);

    localparam int ADDR_W = $clog2(LOG_SLOTS);
    localparam int WIDE_W = palt_pkg::WIDE_IDX_W;

    palt_pkg::t_state            r_state, n_state;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic                        clr_last;
    logic [palt_pkg::GROUP_W-1:0] r_own_group;

    palt_pkg::t_req              r_req;
    logic [ADDR_W-1:0]           r_req_addr;
    logic                        r_busy;
    logic                        r_fwd_hit;
    palt_pkg::t_slot             r_fwd_word;
    palt_pkg::t_resp             r_out;
    logic                        r_out_valid;

    logic                        in_acc;
    logic                        out_free;
    logic                        complete;
    logic [WIDE_W-1:0]           idx_wide;
    logic [ADDR_W-1:0]           rd_addr;
    palt_pkg::t_slot             rd_data;
    palt_pkg::t_slot             slot_cur;

    logic                        dec_wr_en;
    palt_pkg::t_slot             dec_wr_slot;
    palt_pkg::t_resp             dec_resp;

    logic                        mem_wr_en;
    logic [ADDR_W-1:0]           mem_wr_addr;
    palt_pkg::t_slot             mem_wr_data;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= palt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // clearing pass ends on the last slot
    assign clr_last = (r_clr_addr == ADDR_W'(LOG_SLOTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            palt_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = palt_pkg::ST_RUN;
                end
            end
            palt_pkg::ST_RUN: begin
                n_state = palt_pkg::ST_RUN;
            end
            default: begin
                n_state = palt_pkg::ST_CLEAR;
            end
        endcase
    end

    // clearing address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == palt_pkg::ST_CLEAR && !clr_last) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // own group register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_group <= '0;
        end else if (i_cfg_wr_en) begin
            r_own_group <= i_cfg_wr_data;
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign complete   = r_busy && out_free;
    assign o_in_stall = (r_state != palt_pkg::ST_RUN) || (r_busy && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    // slot address and range check
    assign idx_wide = WIDE_W'(i_log_index);
    assign rd_addr  = idx_wide[ADDR_W-1:0];

    // lookup stage: request register and forwarding of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (in_acc) begin
            r_busy    <= 1'b1;
            r_fwd_hit <= mem_wr_en && (mem_wr_addr == rd_addr);
        end else if (complete) begin
            r_busy    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= '{op: palt_pkg::t_op'(i_operation), group: i_request_group,
                            in_range: (idx_wide < WIDE_W'(LOG_SLOTS)),
                            prop: i_proposal_number, value: i_value_id};
            r_fwd_word <= mem_wr_data;
        end
    end

    // address of the request in lookup
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_addr <= rd_addr;
        end
    end

    assign slot_cur = r_fwd_hit ? r_fwd_word : rd_data;

    palt_slot_ram #(
        .DEPTH  (LOG_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    palt_decide u_decide (
        .i_req       (r_req),
        .i_own_group (r_own_group),
        .i_slot      (slot_cur),
        .o_wr_en     (dec_wr_en),
        .o_wr_slot   (dec_wr_slot),
        .o_resp      (dec_resp)
    );

    // memory write: clearing pass or slot write-back
    always_comb begin
        if (r_state == palt_pkg::ST_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_clr_addr;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = complete && dec_wr_en;
            mem_wr_addr = r_req.in_range ? r_req_addr : '0;
            mem_wr_data = dec_wr_slot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_out <= dec_resp;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_code       = r_out.code;
    assign o_returned_proposal = r_out.prop;
    assign o_value_present     = r_out.present;
    assign o_returned_value    = r_out.value;

    // no request taken while the table is being cleared
    `PALT_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == palt_pkg::ST_CLEAR, o_in_stall)
    // slot write-back only when a lookup completes
    `PALT_ASSERT_NOW(a_wr_on_complete, i_clk, i_rst_n, (r_state == palt_pkg::ST_RUN) && mem_wr_en, complete)
    // a completed lookup always presents a result
    `PALT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, complete, o_out_valid)

endmodule

`default_nettype wire

### design/palt_slot_ram.sv
// ----------------------------------------------------------------------------
// palt_slot_ram
// Synchronous slot memory: one write port, one read port, registered read
// data (read-before-write on a shared address).
// ----------------------------------------------------------------------------
`default_nettype none

module palt_slot_ram #(
    parameter int DEPTH  = palt_pkg::LOG_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output palt_pkg::t_slot          o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire palt_pkg::t_slot     i_wr_data
);

    palt_pkg::t_slot r_mem [DEPTH];
    palt_pkg::t_slot r_rd_data;

    // read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/palt_decide.sv
// ----------------------------------------------------------------------------
// palt_decide
// Acceptor decision for one request against the current slot contents:
// result code, returned fields and the updated slot.
// ----------------------------------------------------------------------------
`default_nettype none

module palt_decide (
    input  wire palt_pkg::t_req                     i_req,
    input  wire logic [palt_pkg::GROUP_W-1:0]       i_own_group,
    input  wire palt_pkg::t_slot                    i_slot,
    output logic                                    o_wr_en,
    output palt_pkg::t_slot                         o_wr_slot,
    output palt_pkg::t_resp                         o_resp
);

    logic [palt_pkg::NUM_W-1:0] held_val;

    // value handle is only returned when one is held
    assign held_val = i_slot.held ? i_slot.value : '0;

    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_slot = i_slot;
        o_resp    = '{code: palt_pkg::CODE_OK, prop: '0, present: 1'b0, value: '0};

        if (i_req.group != i_own_group) begin
            o_resp.code = palt_pkg::CODE_GROUP;
        end else if (!i_req.in_range) begin
            o_resp.code = palt_pkg::CODE_LOW;
        end else if (i_req.op == palt_pkg::OP_PREPARE) begin
            if (!i_slot.used) begin
                // first touch: promise, nothing accepted
                o_wr_en   = 1'b1;
                o_wr_slot = '{used: 1'b1, promised: i_req.prop, accepted: '0,
                              held: 1'b0, value: '0};
            end else begin
                o_resp.prop    = i_slot.accepted;
                o_resp.present = i_slot.held;
                o_resp.value   = held_val;
                if (i_slot.promised < i_req.prop) begin
                    o_wr_en            = 1'b1;
                    o_wr_slot.promised = i_req.prop;
                end else begin
                    o_resp.code = palt_pkg::CODE_LOW;
                end
            end
        end else begin
            if (i_slot.used && (i_slot.promised > i_req.prop)) begin
                o_resp.code    = palt_pkg::CODE_LOW;
                o_resp.prop    = i_slot.accepted;
                o_resp.present = i_slot.held;
                o_resp.value   = held_val;
            end else if (i_slot.used && i_slot.held) begin
                o_resp.code    = palt_pkg::CODE_CHOSEN;
                o_resp.prop    = i_slot.accepted;
                o_resp.present = 1'b1;
                o_resp.value   = i_slot.value;
            end else begin
                // store the value under this proposal
                o_wr_en        = 1'b1;
                o_wr_slot      = '{used: 1'b1, promised: i_req.prop,
                                   accepted: i_req.prop, held: 1'b1,
                                   value: i_req.value};
                o_resp.prop    = i_req.prop;
                o_resp.present = 1'b1;
                o_resp.value   = i_req.value;
            end
        end
    end

endmodule

`default_nettype wire
